// File: rtl/psg_three_voice_sound_generator_unit_assert.svh
// Assertion macros for the sound generator checker.
// Both expect i_clk and i_rst_n in scope.
`ifndef PSG_THREE_VOICE_SOUND_GENERATOR_UNIT_ASSERT_SVH
`define PSG_THREE_VOICE_SOUND_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PSG_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PSG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

// File: rtl/psg_pkg.sv
package psg_pkg;

    localparam int NUM_REGISTERS = 16;
    localparam int REG_AW        = 4;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ENV_HOLD = 2'd0,
        ENV_UP   = 2'd1,
        ENV_DOWN = 2'd2
    } t_env_step;

    localparam logic [3:0] REG_TONE_A_FINE   = 4'd0;
    localparam logic [3:0] REG_TONE_A_COARSE = 4'd1;
    localparam logic [3:0] REG_TONE_B_FINE   = 4'd2;
    localparam logic [3:0] REG_TONE_B_COARSE = 4'd3;
    localparam logic [3:0] REG_TONE_C_FINE   = 4'd4;
    localparam logic [3:0] REG_TONE_C_COARSE = 4'd5;
    localparam logic [3:0] REG_NOISE_PER     = 4'd6;
    localparam logic [3:0] REG_MIXER         = 4'd7;
    localparam logic [3:0] REG_VOL_A         = 4'd8;
    localparam logic [3:0] REG_VOL_B         = 4'd9;
    localparam logic [3:0] REG_VOL_C         = 4'd10;
    localparam logic [3:0] REG_ENV_FINE      = 4'd11;
    localparam logic [3:0] REG_ENV_COARSE    = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE     = 4'd13;

    localparam logic [7:0] MASK_NIBBLE = 8'h0F;
    localparam logic [7:0] MASK_FIVE   = 8'h1F;
    localparam logic [7:0] RD_UNMAPPED = 8'hFF;

    localparam logic [4:0]  ENV_TOP    = 5'd31;
    localparam logic [16:0] LFSR_RESET = 17'h0FFFF;

    // Register file decoded for the generators.
    typedef struct packed {
        logic [2:0][11:0] tone_per;
        logic [4:0]       noise_per;
        logic [5:0]       mixer;
        logic [2:0][4:0]  vol;
        logic [15:0]      env_per;
        logic [3:0]       shape;
    } t_gen_cfg;

    typedef struct packed {
        logic tick;
        logic restart;
        logic attack;
    } t_gen_ctl;

endpackage

// File: rtl/psg_regs.sv
module psg_regs
    import psg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [REG_AW-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [REG_AW-1:0] i_raddr,
    output logic [7:0]        o_rdata,
    output t_gen_cfg          o_cfg
);

    logic [7:0] r_regs [NUM_REGISTERS];
    logic [7:0] n_wval;

    always_comb begin
        n_wval = i_wdata;
        if (i_waddr inside {REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE,
                            REG_ENV_SHAPE}) begin
            n_wval = i_wdata & MASK_NIBBLE;
        end else if (i_waddr inside {REG_NOISE_PER, REG_VOL_A, REG_VOL_B, REG_VOL_C}) begin
            n_wval = i_wdata & MASK_FIVE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGISTERS; i++) begin
                r_regs[i] <= '0;
            end
        end else if (i_we) begin
            r_regs[i_waddr] <= n_wval;
        end
    end

    assign o_rdata = r_regs[i_raddr];

    always_comb begin
        o_cfg.tone_per[0] = {r_regs[REG_TONE_A_COARSE][3:0], r_regs[REG_TONE_A_FINE]};
        o_cfg.tone_per[1] = {r_regs[REG_TONE_B_COARSE][3:0], r_regs[REG_TONE_B_FINE]};
        o_cfg.tone_per[2] = {r_regs[REG_TONE_C_COARSE][3:0], r_regs[REG_TONE_C_FINE]};
        o_cfg.noise_per   = r_regs[REG_NOISE_PER][4:0];
        o_cfg.mixer       = r_regs[REG_MIXER][5:0];
        o_cfg.vol[0]      = r_regs[REG_VOL_A][4:0];
        o_cfg.vol[1]      = r_regs[REG_VOL_B][4:0];
        o_cfg.vol[2]      = r_regs[REG_VOL_C][4:0];
        o_cfg.env_per     = {r_regs[REG_ENV_COARSE], r_regs[REG_ENV_FINE]};
        o_cfg.shape       = r_regs[REG_ENV_SHAPE][3:0];
    end

endmodule

// File: rtl/psg_gen.sv
module psg_gen
    import psg_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_gen_ctl        i_ctl,
    input  t_gen_cfg        i_cfg,
    output logic [2:0][4:0] o_levels
);

    logic [2:0][11:0] r_tone_cnt, n_tone_cnt;
    logic [2:0]       r_tone_ph,  n_tone_ph;
    logic [5:0]       r_noise_cnt, n_noise_cnt;
    logic [16:0]      r_lfsr, n_lfsr;
    logic             r_noise_bit, n_noise_bit;
    logic [15:0]      r_env_cnt, n_env_cnt;
    logic [4:0]       r_env_lvl, n_env_lvl;
    t_env_step        r_env_step, n_env_step;
    logic [2:0][4:0]  r_levels, n_levels;

    logic [12:0] tone_inc;
    logic [6:0]  noise_inc;
    logic [16:0] env_inc;
    logic        env_under, env_over;
    logic [4:0]  amp;

    always_comb begin
        n_tone_cnt  = r_tone_cnt;
        n_tone_ph   = r_tone_ph;
        n_noise_cnt = r_noise_cnt;
        n_lfsr      = r_lfsr;
        n_noise_bit = r_noise_bit;
        n_env_cnt   = r_env_cnt;
        n_env_lvl   = r_env_lvl;
        n_env_step  = r_env_step;
        n_levels    = r_levels;
        tone_inc    = '0;
        noise_inc   = {1'b0, r_noise_cnt} + 7'd1;
        env_inc     = {1'b0, r_env_cnt} + 17'd1;
        env_under   = (r_env_step == ENV_DOWN) && (r_env_lvl == 5'd0);
        env_over    = (r_env_step == ENV_UP) && (r_env_lvl == ENV_TOP);
        amp         = '0;

        if (i_ctl.restart) begin
            n_env_cnt  = '0;
            n_env_lvl  = i_ctl.attack ? 5'd0 : ENV_TOP;
            n_env_step = i_ctl.attack ? ENV_UP : ENV_DOWN;
        end else if (i_ctl.tick) begin
            for (int i = 0; i < 3; i++) begin
                tone_inc = {1'b0, r_tone_cnt[i]} + 13'd1;
                if (tone_inc >= {1'b0, i_cfg.tone_per[i]}) begin
                    n_tone_cnt[i] = '0;
                    n_tone_ph[i]  = ~r_tone_ph[i];
                end else begin
                    n_tone_cnt[i] = tone_inc[11:0];
                end
            end

            // noise period register counts in half-periods
            if (noise_inc >= {1'b0, i_cfg.noise_per, 1'b0}) begin
                n_noise_cnt = '0;
                n_lfsr      = {r_lfsr[15:0], 1'b1} ^ {16'd0, r_lfsr[16] ^ r_lfsr[13]};
                n_noise_bit = n_lfsr[16];
            end else begin
                n_noise_cnt = noise_inc[5:0];
            end

            if (env_inc >= {1'b0, i_cfg.env_per}) begin
                n_env_cnt = '0;
                if (env_under || env_over) begin
                    if (i_cfg.shape inside {[4'd0:4'd7], 4'd9, 4'd15}) begin
                        n_env_lvl  = 5'd0;
                        n_env_step = ENV_HOLD;
                    end else if (i_cfg.shape inside {4'd8, 4'd12}) begin
                        n_env_lvl = env_under ? ENV_TOP : 5'd0;
                    end else if (i_cfg.shape inside {4'd10, 4'd14}) begin
                        // bounce: level stays at the edge, direction flips
                        n_env_step = env_under ? ENV_UP : ENV_DOWN;
                    end else begin
                        n_env_lvl  = ENV_TOP;
                        n_env_step = ENV_HOLD;
                    end
                end else begin
                    case (r_env_step)
                        ENV_UP:   n_env_lvl = r_env_lvl + 5'd1;
                        ENV_DOWN: n_env_lvl = r_env_lvl - 5'd1;
                        default:  n_env_lvl = r_env_lvl;
                    endcase
                end
            end else begin
                n_env_cnt = env_inc[15:0];
            end

            for (int i = 0; i < 3; i++) begin
                amp = i_cfg.vol[i][4] ? n_env_lvl : {i_cfg.vol[i][3:0], 1'b1};
                n_levels[i] = ((n_tone_ph[i] | i_cfg.mixer[i]) &
                               (n_noise_bit | i_cfg.mixer[i+3])) ? amp : 5'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_cnt  <= '0;
            r_tone_ph   <= '0;
            r_noise_cnt <= '0;
            r_lfsr      <= LFSR_RESET;
            r_noise_bit <= 1'b0;
            r_env_cnt   <= '0;
            r_env_lvl   <= ENV_TOP;
            r_env_step  <= ENV_DOWN;
            r_levels    <= '0;
        end else begin
            r_tone_cnt  <= n_tone_cnt;
            r_tone_ph   <= n_tone_ph;
            r_noise_cnt <= n_noise_cnt;
            r_lfsr      <= n_lfsr;
            r_noise_bit <= n_noise_bit;
            r_env_cnt   <= n_env_cnt;
            r_env_lvl   <= n_env_lvl;
            r_env_step  <= n_env_step;
            r_levels    <= n_levels;
        end
    end

    assign o_levels = n_levels;

endmodule

// File: rtl/psg_three_voice_sound_generator_unit.sv
// Three-voice sound generator, register-compatible with the classic PSG parts.
// Request channel (s_axis): tuser carries the op (write, read, tick, no-op),
// tdata carries the register address and the data byte.
// Result channel (m_axis): exactly one result per request, in order: read data
// (zero unless the op is a read) and the three 5-bit channel levels. Levels
// change only on a tick; other ops repeat the last levels.
// i_cfg_we/i_cfg_wdata set the AY address fold (low four address bits only);
// write it only while no request is in flight.
// Throughput: one request per cycle while the result side is not stalled, set by
// the single register-to-register pass that updates the register file,
// dividers, LFSR and envelope.
// A request holding stage and a result register sit on either side, so a
// request is still taken while one result waits; when m_axis_tready stays low
// the result holds and at most one more request is buffered, then
// s_axis_tready drops.
// Synchronous reset clears the register file, counters and levels, loads the
// LFSR and starts the envelope in decay at full level; both channels go empty.
module psg_three_voice_sound_generator_unit
    import psg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] reg_addr, [15:8] reg_data
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [7:0] read_data, [12:8] level_a,
                                        // [17:13] level_b, [22:18] level_c, [23] zero
);

    logic            r_chip_is_ay;
    logic            r_in_valid;
    t_op             r_in_op;
    logic [7:0]      r_in_addr;
    logic [7:0]      r_in_data;
    logic            r_out_valid;
    logic [23:0]     r_out_data;

    logic            fire;
    logic [7:0]      addr;
    logic            addr_high;
    logic [7:0]      reg_rdata;
    logic [7:0]      n_read_data;
    logic [2:0][4:0] levels;
    t_gen_cfg        gen_cfg;
    t_gen_ctl        gen_ctl;

    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;

    assign addr      = r_chip_is_ay ? {4'd0, r_in_addr[3:0]} : r_in_addr;
    assign addr_high = |addr[7:REG_AW];

    assign gen_ctl.tick    = fire && (r_in_op == OP_TICK);
    assign gen_ctl.restart = fire && (r_in_op == OP_WRITE) && !addr_high &&
                             (addr[REG_AW-1:0] == REG_ENV_SHAPE);
    assign gen_ctl.attack  = r_in_data[2];

    always_comb begin
        case (r_in_op)
            OP_READ: n_read_data = addr_high ? RD_UNMAPPED : reg_rdata;
            default: n_read_data = '0;
        endcase
    end

    psg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (fire && (r_in_op == OP_WRITE) && !addr_high),
        .i_waddr (addr[REG_AW-1:0]),
        .i_wdata (r_in_data),
        .i_raddr (addr[REG_AW-1:0]),
        .o_rdata (reg_rdata),
        .o_cfg   (gen_cfg)
    );

    psg_gen u_gen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (gen_ctl),
        .i_cfg    (gen_cfg),
        .o_levels (levels)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_is_ay <= 1'b0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_chip_is_ay <= i_cfg_wdata;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= t_op'(s_axis_tuser);
            r_in_addr <= s_axis_tdata[7:0];
            r_in_data <= s_axis_tdata[15:8];
        end
        if (fire) begin
            r_out_data <= {1'b0, levels[2], levels[1], levels[0], n_read_data};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// File: rtl/psg_chk.sv
`include "psg_three_voice_sound_generator_unit_assert.svh"

module psg_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // stalled result must not change
    `PSG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // an accepted request must be followed by a valid result in the result register
    `PSG_ASSERT_NEXT(a_latency, s_axis_tvalid && s_axis_tready,
        ##1 m_axis_tvalid, "request did not reach the result register")

    // input only backs up when the result register is blocked
    `PSG_ASSERT_IMPL(a_backpressure, !s_axis_tready,
        m_axis_tvalid && !m_axis_tready, "request stalled with output free")

    `PSG_ASSERT_IMPL(a_pad_zero, m_axis_tvalid,
        !m_axis_tdata[23], "padding bit set in result")

endmodule

bind psg_three_voice_sound_generator_unit psg_chk u_psg_chk (.*);

// File: tb/sv/psg_three_voice_sound_generator_unit_tb.sv
module psg_three_voice_sound_generator_unit_tb;
    import psg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [4:0] lc;
        logic [4:0] lb;
        logic [4:0] la;
        logic [7:0] rd;
    } t_psg_out;

    typedef struct packed {
        t_op        op;
        logic [7:0] addr;
        logic [7:0] data;
        logic       rd_typed;
        logic [7:0] rd_val;
        logic       lvl_typed;
    } t_dir_row;

    localparam int NUM_DIR_ROWS = 24;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_wdata   = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;  // [7:0] reg_addr, [15:8] reg_data
    logic [1:0]  s_axis_tuser  = '0;  // [1:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // [7:0] read_data, [12:8] level_a,
                                      // [17:13] level_b, [22:18] level_c

    // Shadow of the generator state
    logic [7:0]  psg_regs [NUM_REGISTERS];
    logic [11:0] psg_tone_cnt [3];
    logic        psg_tone_ph [3];
    logic [5:0]  psg_noise_cnt;
    logic [16:0] psg_lfsr;
    logic        psg_noise_out;
    logic [15:0] psg_env_cnt;
    logic [4:0]  psg_env_lvl;
    t_env_step   psg_env_dir;
    logic [4:0]  psg_lvl [3];
    logic        ay_fold;

    t_psg_out    psg_out_fifo [$];
    int          errors     = 0;
    int          n_checked  = 0;
    int          n_op [4]   = '{0, 0, 0, 0};
    bit          calm_tail  = 1'b0;
    int          rx_hold    = 0;

    t_dir_row dir_rows [NUM_DIR_ROWS] = '{
        '{OP_READ,  8'h00, 8'h00, 1'b1, 8'h00, 1'b1},
        '{OP_READ,  8'hFF, 8'h00, 1'b1, 8'hFF, 1'b1},
        '{OP_WRITE, 8'h01, 8'hFF, 1'b1, 8'h00, 1'b1},
        '{OP_READ,  8'h01, 8'h00, 1'b1, 8'h0F, 1'b1},
        '{OP_WRITE, 8'h08, 8'hFF, 1'b1, 8'h00, 1'b1},
        '{OP_READ,  8'h08, 8'h00, 1'b1, 8'h1F, 1'b1},
        '{OP_WRITE, 8'h80, 8'hAA, 1'b1, 8'h00, 1'b1},
        '{OP_READ,  8'h80, 8'h00, 1'b1, 8'hFF, 1'b1},
        '{OP_NOP,   8'h05, 8'hFF, 1'b1, 8'h00, 1'b1},
        '{OP_WRITE, 8'h0D, 8'hFF, 1'b1, 8'h00, 1'b1},
        '{OP_READ,  8'h0D, 8'h00, 1'b1, 8'h0F, 1'b1},
        '{OP_WRITE, 8'h07, 8'h00, 1'b1, 8'h00, 1'b1},
        '{OP_WRITE, 8'h0B, 8'h00, 1'b1, 8'h00, 1'b1},
        '{OP_TICK,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        // shape restart, then the same value again
        '{OP_WRITE, 8'h0D, 8'h0E, 1'b1, 8'h00, 1'b0},
        '{OP_WRITE, 8'h0D, 8'h0E, 1'b1, 8'h00, 1'b0},
        '{OP_TICK,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{OP_WRITE, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        '{OP_TICK,  8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{OP_WRITE, 8'h00, 8'hFF, 1'b1, 8'h00, 1'b0},
        '{OP_TICK,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        // counter still below the new period
        '{OP_WRITE, 8'h00, 8'h01, 1'b1, 8'h00, 1'b0},
        '{OP_TICK,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{OP_TICK,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0}
    };

    psg_three_voice_sound_generator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void psg_model_reset();
        int i;
        for (i = 0; i < NUM_REGISTERS; i++) psg_regs[i] = '0;
        for (i = 0; i < 3; i++) begin
            psg_tone_cnt[i] = '0;
            psg_tone_ph[i]  = 1'b0;
            psg_lvl[i]      = '0;
        end
        psg_noise_cnt = '0;
        psg_lfsr      = LFSR_RESET;
        psg_noise_out = 1'b0;
        psg_env_cnt   = '0;
        psg_env_lvl   = ENV_TOP;
        psg_env_dir   = ENV_DOWN;
        ay_fold       = 1'b0;
    endfunction

    function automatic void psg_write_reg(logic [7:0] a, logic [7:0] v);
        if (a >= NUM_REGISTERS) return;
        case (a[3:0])
            REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE, REG_ENV_SHAPE:
                v &= MASK_NIBBLE;
            REG_NOISE_PER, REG_VOL_A, REG_VOL_B, REG_VOL_C:
                v &= MASK_FIVE;
            default: ;
        endcase
        psg_regs[a[3:0]] = v;
        if (a[3:0] == REG_ENV_SHAPE) begin
            psg_env_cnt = '0;
            if (v[2]) begin
                psg_env_lvl = '0;
                psg_env_dir = ENV_UP;
            end else begin
                psg_env_lvl = ENV_TOP;
                psg_env_dir = ENV_DOWN;
            end
        end
    endfunction

    function automatic void psg_env_advance();
        int         nxt;
        logic [3:0] shape;
        shape = psg_regs[REG_ENV_SHAPE][3:0];
        nxt = int'(psg_env_lvl) + ((psg_env_dir == ENV_UP) ? 1 :
                                   (psg_env_dir == ENV_DOWN) ? -1 : 0);
        if (nxt < 0 || nxt > 31) begin
            if (shape < 8 || shape == 9 || shape == 15) begin
                nxt = 0;
                psg_env_dir = ENV_HOLD;
            end else if (shape == 8 || shape == 12) begin
                nxt = (nxt < 0) ? 31 : 0;     // sawtooth wraps
            end else if (shape == 10 || shape == 14) begin
                psg_env_dir = (psg_env_dir == ENV_UP) ? ENV_DOWN : ENV_UP;
                nxt += (psg_env_dir == ENV_UP) ? 1 : -1;
            end else begin
                nxt = 31;
                psg_env_dir = ENV_HOLD;
            end
        end
        psg_env_lvl = nxt[4:0];
    endfunction

    function automatic void psg_tick();
        int         i;
        int         per;
        int         c;
        logic [7:0] vreg;
        logic [4:0] amp;
        logic       tone_on;
        logic       noise_on;
        logic       fb;
        for (i = 0; i < 3; i++) begin
            per = {psg_regs[2 * i + 1][3:0], psg_regs[2 * i]};
            c = psg_tone_cnt[i] + 1;
            if (c >= per) begin
                c = 0;
                psg_tone_ph[i] = ~psg_tone_ph[i];
            end
            psg_tone_cnt[i] = c[11:0];
        end

        c = psg_noise_cnt + 1;
        if (c >= psg_regs[REG_NOISE_PER] * 2) begin
            fb = psg_lfsr[16] ^ psg_lfsr[13];
            c = 0;
            psg_lfsr = {psg_lfsr[15:0], 1'b1} ^ {16'd0, fb};
            psg_noise_out = psg_lfsr[16];
        end
        psg_noise_cnt = c[5:0];

        per = {psg_regs[REG_ENV_COARSE], psg_regs[REG_ENV_FINE]};
        c = psg_env_cnt + 1;
        if (c >= per) begin
            c = 0;
            psg_env_advance();
        end
        psg_env_cnt = c[15:0];

        for (i = 0; i < 3; i++) begin
            vreg     = psg_regs[REG_VOL_A + i];
            tone_on  = psg_tone_ph[i] | psg_regs[REG_MIXER][i];
            noise_on = psg_noise_out | psg_regs[REG_MIXER][i + 3];
            amp      = vreg[4] ? psg_env_lvl : {vreg[3:0], 1'b1};
            psg_lvl[i] = (tone_on && noise_on) ? amp : 5'd0;
        end
    endfunction

    function automatic t_psg_out psg_apply_request(t_op op, logic [7:0] addr,
                                                   logic [7:0] data);
        logic [7:0] a;
        t_psg_out   r;
        a = ay_fold ? {4'h0, addr[3:0]} : addr;
        r = '0;
        case (op)
            OP_WRITE: psg_write_reg(a, data);
            OP_READ:  r.rd = (a >= NUM_REGISTERS) ? RD_UNMAPPED : psg_regs[a[3:0]];
            OP_TICK:  psg_tick();
            default: ;
        endcase
        r.la = psg_lvl[0];
        r.lb = psg_lvl[1];
        r.lc = psg_lvl[2];
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic push_request(t_op op, logic [7:0] addr, logic [7:0] data,
                                bit rd_typed, logic [7:0] rd_val, bit lvl_typed);
        t_psg_out want;
        if (!calm_tail && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 16'($urandom);
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {data, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        want = psg_apply_request(op, addr, data);
        if (rd_typed) want.rd = rd_val;
        if (lvl_typed) begin
            want.la = '0;
            want.lb = '0;
            want.lc = '0;
        end
        psg_out_fifo.push_back(want);
        n_op[op]++;
        @(negedge i_clk);
    endtask

    task automatic drain_outputs(int settle);
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (psg_out_fifo.size() != 0 && guard < 5000) begin
            @(negedge i_clk);
            guard++;
        end
        if (psg_out_fifo.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     psg_out_fifo.size());
            errors++;
        end
        repeat (settle) @(negedge i_clk);
    endtask

    // Result side back-pressure in random bursts
    always @(negedge i_clk) begin
        if (rx_hold != 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= $urandom_range(0, 6);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_psg_out want;
        t_psg_out got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[22:0];
            if (psg_out_fifo.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         m_axis_tdata);
                errors++;
            end else begin
                want = psg_out_fifo.pop_front();
                n_checked++;
                if (got.rd !== want.rd) begin
                    $display("%0t: read_data expected %h actual %h", $time, want.rd, got.rd);
                    errors++;
                end
                if (got.la !== want.la) begin
                    $display("%0t: level_a expected %0d actual %0d", $time, want.la, got.la);
                    errors++;
                end
                if (got.lb !== want.lb) begin
                    $display("%0t: level_b expected %0d actual %0d", $time, want.lb, got.lb);
                    errors++;
                end
                if (got.lc !== want.lc) begin
                    $display("%0t: level_c expected %0d actual %0d", $time, want.lc, got.lc);
                    errors++;
                end
                if (m_axis_tdata[23] !== 1'b0) begin
                    $display("%0t: pad bit expected 0 actual %b", $time, m_axis_tdata[23]);
                    errors++;
                end
            end
        end
    end

    initial begin
        int         ph;
        int         n;
        int         pick;
        t_op        op;
        logic [7:0] a;
        logic [7:0] d;

        psg_model_reset();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // AY fold off, on, off, on
        for (ph = 0; ph < 4; ph++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= ph[0];
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            ay_fold = ph[0];

            if (ph == 0) begin
                for (n = 0; n < NUM_DIR_ROWS; n++)
                    push_request(dir_rows[n].op, dir_rows[n].addr, dir_rows[n].data,
                                 dir_rows[n].rd_typed, dir_rows[n].rd_val,
                                 dir_rows[n].lvl_typed);
            end

            for (n = 0; n < 200; n++) begin
                if (ph == 1 && n == 100) drain_outputs(0);
                if (ph == 3 && n == 100) calm_tail = 1'b1;

                pick = $urandom_range(0, 99);
                if (pick < 55)      op = OP_TICK;
                else if (pick < 80) op = OP_WRITE;
                else if (pick < 95) op = OP_READ;
                else                op = OP_NOP;

                a = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(16, 255))
                                                : 8'($urandom_range(0, 15));
                // keep periods short most of the time so the dividers wrap
                case (a[3:0])
                    REG_TONE_A_FINE, REG_TONE_B_FINE, REG_TONE_C_FINE:
                        d = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, 15));
                    REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE,
                    REG_ENV_COARSE:
                        d = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'd0;
                    REG_ENV_FINE:
                        d = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, 3));
                    default:
                        d = 8'($urandom);
                endcase
                push_request(op, a, d, 1'b0, 8'h00, 1'b0);
            end
            drain_outputs(4);
        end

        $display("Ran %0d ticks, %0d writes, %0d reads, %0d no-ops; %0d results checked,",
                 n_op[OP_TICK], n_op[OP_WRITE], n_op[OP_READ], n_op[OP_NOP], n_checked);
        $display("with the AY address fold both off and on and random stalls on both sides.");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #200_000;
        $display("Timeout at %0t", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
